FILE: sv/clns_pkg.sv
// clns_pkg: shared types, constants and the microcode program of the
// character lcd nibble sequencer. No dependencies.
`timescale 1ns / 1ps

package clns_pkg;

  localparam int STEP_W = 5;
  localparam int HOLD_W = 19;
  localparam int CYC_W  = 27;

  localparam logic [STEP_W-1:0] INIT_ENTRY = 5'd0;
  localparam logic [STEP_W-1:0] BYTE_ENTRY = 5'd25;

  localparam logic [HOLD_W-1:0] STROBE_US = 19'd20;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_CMD    = 2'd1,
    OP_DATA   = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    NIB_ZERO  = 2'd0,
    NIB_CONST = 2'd1,
    NIB_HI    = 2'd2,
    NIB_LO    = 2'd3
  } nib_sel_t;

  typedef enum logic [2:0] {
    HOLD_20     = 3'd0,
    HOLD_100    = 3'd1,
    HOLD_5000   = 3'd2,
    HOLD_10000  = 3'd3,
    HOLD_50000  = 3'd4,
    HOLD_500000 = 3'd5
  } hold_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WAIT
  } state_t;

  // one microcode word
  typedef struct packed {
    nib_sel_t   nib_sel;
    logic [3:0] nib_const;
    logic       en;
    hold_sel_t  hold;
    logic       ld;        // load ld_byte into the byte register when the beat goes out
    logic [7:0] ld_byte;
    logic       last;
  } ctrl_t;

  function automatic logic [HOLD_W-1:0] hold_us_of(hold_sel_t h);
    logic [HOLD_W-1:0] r;
    unique case (h)
      HOLD_20:     r = 19'd20;
      HOLD_100:    r = 19'd100;
      HOLD_5000:   r = 19'd5000;
      HOLD_10000:  r = 19'd10000;
      HOLD_50000:  r = 19'd50000;
      HOLD_500000: r = 19'd500000;
      default:     r = 19'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] r;
    unique case (row)
      2'd0:    r = 8'h80;
      2'd1:    r = 8'hC0;
      2'd2:    r = 8'h94;
      default: r = 8'hD4;
    endcase
    return r;
  endfunction

  function automatic ctrl_t cw(nib_sel_t s, logic [3:0] k, logic en, hold_sel_t h,
                               logic ld, logic [7:0] b, logic last);
    ctrl_t c;
    c.nib_sel   = s;
    c.nib_const = k;
    c.en        = en;
    c.hold      = h;
    c.ld        = ld;
    c.ld_byte   = b;
    c.last      = last;
    return c;
  endfunction

  // the program: init from INIT_ENTRY, byte write from BYTE_ENTRY
  function automatic ctrl_t ucode_rom(logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step) inside
      5'd0:                 c = cw(NIB_ZERO,  4'd0, 1'b0, HOLD_500000, 1'b0, 8'h00, 1'b0);
      5'd1, 5'd3, 5'd5:     c = cw(NIB_CONST, 4'd3, 1'b1, HOLD_20,     1'b0, 8'h00, 1'b0);
      5'd2, 5'd4:           c = cw(NIB_CONST, 4'd3, 1'b0, HOLD_50000,  1'b0, 8'h00, 1'b0);
      5'd6:                 c = cw(NIB_CONST, 4'd3, 1'b0, HOLD_10000,  1'b0, 8'h00, 1'b0);
      5'd7:                 c = cw(NIB_CONST, 4'd2, 1'b1, HOLD_20,     1'b0, 8'h00, 1'b0);
      5'd8:                 c = cw(NIB_CONST, 4'd2, 1'b0, HOLD_10000,  1'b1, 8'h01, 1'b0);
      5'd9, 5'd13, 5'd17, 5'd21, 5'd25:
                            c = cw(NIB_HI,    4'd0, 1'b1, HOLD_20,     1'b0, 8'h00, 1'b0);
      5'd10, 5'd14, 5'd18, 5'd22, 5'd26:
                            c = cw(NIB_HI,    4'd0, 1'b0, HOLD_100,    1'b0, 8'h00, 1'b0);
      5'd11, 5'd15, 5'd19, 5'd23, 5'd27:
                            c = cw(NIB_LO,    4'd0, 1'b1, HOLD_20,     1'b0, 8'h00, 1'b0);
      5'd12:                c = cw(NIB_LO,    4'd0, 1'b0, HOLD_5000,   1'b1, 8'h06, 1'b0);
      5'd16:                c = cw(NIB_LO,    4'd0, 1'b0, HOLD_5000,   1'b1, 8'h0F, 1'b0);
      5'd20:                c = cw(NIB_LO,    4'd0, 1'b0, HOLD_5000,   1'b1, 8'h0C, 1'b0);
      5'd24, 5'd28:         c = cw(NIB_LO,    4'd0, 1'b0, HOLD_5000,   1'b0, 8'h00, 1'b1);
      default:              c = cw(NIB_ZERO,  4'd0, 1'b0, HOLD_20,     1'b0, 8'h00, 1'b1);
    endcase
    return c;
  endfunction

endpackage

FILE: sv/clns_if.sv
// clns_if: valid/ready channel interfaces for requests and pin phases.
// Depends on nothing.
`timescale 1ns / 1ps

interface clns_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] value_byte;
  logic [1:0] row;
  logic [5:0] col;

  modport source (output valid, op, value_byte, row, col, input ready);
  modport sink   (input valid, op, value_byte, row, col, output ready);
endinterface

interface clns_phase_if;
  logic        valid;
  logic        ready;
  logic [3:0]  nibble;
  logic        reg_select;
  logic        enable;
  logic [18:0] hold_us;
  logic        last;

  modport source (output valid, nibble, reg_select, enable, hold_us, last, input ready);
  modport sink   (input valid, nibble, reg_select, enable, hold_us, last, output ready);
endinterface

FILE: sv/clns_sequencer.sv
// clns_sequencer: microcode step counter and program lookup.
// Depends on clns_pkg.
`timescale 1ns / 1ps

module clns_sequencer import clns_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  is_init,
  input  logic  advance,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_addr <= INIT_ENTRY;
    end else if (start) begin
      step_addr <= is_init ? INIT_ENTRY : BYTE_ENTRY;
    end else if (advance && !ctrl.last) begin
      step_addr <= step_addr + 5'd1;
    end
  end

  assign ctrl = ucode_rom(step_addr);

endmodule

FILE: sv/clns_hold_timer.sv
// clns_hold_timer: scales a hold in microseconds to clock cycles and counts it out.
// Depends on clns_pkg.
`timescale 1ns / 1ps

module clns_hold_timer import clns_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [HOLD_W-1:0] hold_us,
  input  logic [7:0]        cycles_per_us,
  output logic              done
);

  logic [HOLD_W-1:0] hold_q;
  logic              pend;
  logic [CYC_W-1:0]  hold_counter;

  always_ff @(posedge clk) begin
    if (load) begin
      hold_q <= hold_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      hold_counter <= '0;
    end else if (load) begin
      pend <= 1'b1;
    end else if (pend) begin
      pend         <= 1'b0;
      hold_counter <= hold_q * cycles_per_us;  // 19 x 8 gives exactly 27 bits
    end else if (hold_counter != '0) begin
      hold_counter <= hold_counter - 27'd1;
    end
  end

  assign done = !load && !pend && (hold_counter <= 27'd1);

endmodule

FILE: sv/char_lcd_nibble_sequencer.sv
// char_lcd_nibble_sequencer: top level of the 4-bit character lcd bus sequencer.
// Depends on clns_pkg, clns_if, clns_sequencer and clns_hold_timer.
`timescale 1ns / 1ps

// usage
//   req   : one beat per request (init, command byte, data byte, cursor move)
//   phase : one beat per pin phase: bus nibble, register select, enable level,
//           hold time in microseconds and a last flag on the final phase
//   cfg_we/cfg_data set clocks_per_microsecond (reset 50); write it while idle
// timing
//   a request is taken only when the block is idle; a byte request gives 4
//   phase beats, init gives 25
//   after each phase beat is taken the block holds for hold_us scaled by
//   clocks_per_microsecond, then offers the next beat
//   a byte request lasts about 5140 us of holds, init about 640640 us;
//   the hold values in the program set these figures
//   first phase beat appears in the cycle after the request is taken
// reset
//   synchronous; returns to idle with req.ready high and no phase beat pending
// stall
//   a phase beat stays offered until taken; the hold starts only when it is,
//   so a slow receiver stretches the sequence but never loses a phase
module char_lcd_nibble_sequencer import clns_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  clns_req_if.sink            req,
  clns_phase_if.source        phase
);

  state_t     state, state_next;
  ctrl_t      ctrl;
  logic [7:0] cycles_per_us;
  logic [7:0] held_byte;
  logic       held_select;
  logic       req_fire, phase_fire;
  logic       seq_advance;
  logic       hold_done;

  assign req_fire   = req.valid && req.ready;
  assign phase_fire = phase.valid && phase.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us <= 8'd50;
    end else if (cfg_we) begin
      cycles_per_us <= cfg_data;
    end
  end

  // byte and register select for the current request; init reloads the byte
  // from the program as each command starts
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte   <= 8'h00;
      held_select <= 1'b0;
    end else if (req_fire) begin
      held_select <= (op_t'(req.op) == OP_DATA);
      if (op_t'(req.op) == OP_CURSOR) begin
        held_byte <= row_base(req.row) + {2'b00, req.col};  // wraps modulo 256
      end else begin
        held_byte <= req.value_byte;
      end
    end else if (phase_fire && ctrl.ld) begin
      held_byte <= ctrl.ld_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    phase.valid = 1'b0;
    seq_advance = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        phase.valid = 1'b1;
        if (phase.ready) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (hold_done) begin
          seq_advance = 1'b1;
          state_next  = ctrl.last ? ST_IDLE : ST_EMIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  clns_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (req_fire),
    .is_init (op_t'(req.op) == OP_INIT),
    .advance (seq_advance),
    .ctrl    (ctrl)
  );

  clns_hold_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .load          (phase_fire),
    .hold_us       (phase.hold_us),
    .cycles_per_us (cycles_per_us),
    .done          (hold_done)
  );

  // phase payload from the current control word and the held byte
  always_comb begin
    unique case (ctrl.nib_sel)
      NIB_ZERO:  phase.nibble = 4'h0;
      NIB_CONST: phase.nibble = ctrl.nib_const;
      NIB_HI:    phase.nibble = held_byte[7:4];
      NIB_LO:    phase.nibble = held_byte[3:0];
      default:   phase.nibble = 4'h0;
    endcase
  end

  assign phase.reg_select = held_select;
  assign phase.enable     = ctrl.en;
  assign phase.hold_us    = hold_us_of(ctrl.hold);
  assign phase.last       = ctrl.last;

endmodule

FILE: sv/clns_checker.sv
// clns_checker: port-level assertions for the sequencer, bound to the top level.
// Depends on clns_pkg and char_lcd_nibble_sequencer.
`timescale 1ns / 1ps

module clns_checker import clns_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_enable,
  input logic [HOLD_W-1:0] out_hold_us
);

  // one request at a time: no new request while a phase is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while a phase beat is offered");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a request beat");

  // every phase is held before the next beat is offered
  a_hold_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("phase beat followed without a hold");

  a_strobe_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_enable) |-> (out_hold_us == STROBE_US))
    else $error("enable-high phase with wrong hold");

  a_out_stays: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("phase beat withdrawn before it was taken");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (phase.valid),
  .out_ready   (phase.ready),
  .out_enable  (phase.enable),
  .out_hold_us (phase.hold_us)
);
